>>> src/sobel_gradient_magnitude_unit_defines.svh
// assertion macros for the sobel gradient magnitude unit
// used by the top level only; expects clk and rst_n in scope
`ifndef SOBEL_GRADIENT_MAGNITUDE_UNIT_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SGM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SGM_ASSERT_SAME(lbl, ante, cons, msg)
`define SGM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/sgm_pkg.sv
// shared types, constants and the square root step for the sobel unit
// no dependencies
package sgm_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int SUM_W     = 11;
  localparam int SQ_W      = 21;
  localparam int RAD_W     = 16;
  localparam int REM_W     = 10;
  localparam int ROOT_W    = 8;

  localparam logic [CFG_W-1:0]  LINE_WIDTH_RST   = 12'd640;
  localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RST = 12'd480;
  localparam logic [ROOT_W-1:0] MAG_MAX          = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } sgm_reg_t;

  // one item in flight through the square root pipe
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              sat;
    logic              last;
  } sgm_sqrt_t;

  // one restoring step: consumes the top two radicand bits, yields one root bit
  function automatic sgm_sqrt_t sqrt_step(sgm_sqrt_t s);
    sgm_sqrt_t         n;
    logic [REM_W+1:0]  rs;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;
    rs    = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W){1'b0}}, s.root, 2'b01};
    ge    = (rs >= trial);
    diff  = rs - trial;
    n      = s;
    n.rem  = ge ? diff[REM_W-1:0] : rs[REM_W-1:0];
    n.root = {s.root[ROOT_W-2:0], ge};
    n.rad  = {s.rad[RAD_W-3:0], 2'b00};
    return n;
  endfunction

endpackage

>>> src/sgm_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on sgm_pkg (sgm_sqrt_t, sqrt_step)
module sgm_isqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sgm_pkg::sgm_sqrt_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sgm_pkg::sgm_sqrt_t out_data
);
  import sgm_pkg::*;

  localparam int STAGES = ROOT_W;

  sgm_sqrt_t          st_r [STAGES];
  logic [STAGES-1:0]  v_r;
  logic [STAGES-1:0]  rdy;

  // a stage may load when empty or when its item moves on
  always_comb begin
    rdy[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st_r[0] <= sqrt_step(in_data);
    end
    for (int k = 1; k < STAGES; k++) begin
      if (rdy[k]) begin
        st_r[k] <= sqrt_step(st_r[k-1]);
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[STAGES-1];
  assign out_data  = st_r[STAGES-1];

endmodule

>>> src/sobel_gradient_magnitude_unit.sv
// channel | direction | payload                          | handshake
// in      | in        | in_pixel[7:0]                    | in_valid / in_ready
// out     | out       | out_magnitude[7:0], out_last_of_frame | out_valid / out_ready
// cfg     | in        | cfg_index, cfg_wdata[11:0]       | cfg_we, no wait
// one item per cycle while out_ready holds; a result passes through the line store read,
// the window and kernel sums, the squares and eight root stages
// the line store is one memory, MAX_WIDTH words of two pixels, read and rewritten per item
// reset is synchronous and clears control and the window; the line store gets no clearing pass
// a stall at the output backs up stage by stage; empty stages keep taking items
// border items leave after the line store stage, updating the window, and never reach the root pipe
`include "sobel_gradient_magnitude_unit_defines.svh"

module sobel_gradient_magnitude_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sgm_pkg::PIX_W-1:0]     in_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sgm_pkg::ROOT_W-1:0]    out_magnitude,
  output logic                          out_last_of_frame,
  input  logic                          cfg_we,
  input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]     cfg_wdata
);
  import sgm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

  // configuration and raster position
  logic [CFG_W-1:0] line_width_r, line_width_nxt;
  logic [CFG_W-1:0] frame_height_r, frame_height_nxt;
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [CW-1:0]    lw_ext, w_eff, col_inc;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W:0]   row_inc;
  logic             col_wrap, row_wrap, produce, is_last;

  // line store stage
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r, fwd_d_r, line_d;
  logic               fwd_r;
  logic               v1_r;
  logic [PIX_W-1:0]   pix1_r;
  logic [AW-1:0]      c1_r;
  logic               prod1_r, last1_r;
  logic [PIX_W-1:0]   top_eff, mid_eff;

  // window and sums
  logic [PIX_W-1:0]        win_r [9];
  logic [PIX_W-1:0]        win_n [9];
  logic [SUM_W-2:0]        sx_pos, sx_neg, sy_pos, sy_neg;
  logic signed [SUM_W-1:0] sx_n, sy_n, sx2_r, sy2_r;
  logic                    v2_r, last2_r;

  // squares
  logic signed [2*SUM_W-1:0] px, py;
  logic [SQ_W-1:0]           sq_n;
  logic [RAD_W-1:0]          sq3_r;
  logic                      v3_r, sat3_r, last3_r;

  logic      in_fire, s1_go, rdy2, rdy3;
  logic      rt_in_ready, rt_out_valid;
  sgm_sqrt_t rt_in, rt_out;

  // ---------------------------------------------------------------- position
  always_comb begin
    lw_ext  = CW'(line_width_r);
    if (lw_ext > MAXW) begin
      w_eff = MAXW;
    end else if (lw_ext == '0) begin
      w_eff = CW'(1);
    end else begin
      w_eff = lw_ext;
    end
    h_eff    = (frame_height_r == '0) ? ROW_W'(1) : frame_height_r;
    col_inc  = CW'(col_r) + CW'(1);
    row_inc  = {1'b0, row_r} + (ROW_W+1)'(1);
    col_wrap = (col_inc >= w_eff);
    row_wrap = (row_inc >= {1'b0, h_eff});
    produce  = (row_r >= ROW_W'(2)) && (col_r >= AW'(2));
    is_last  = (row_inc == {1'b0, h_eff}) && (col_inc == w_eff);
  end

  always_comb begin
    line_width_nxt   = line_width_r;
    frame_height_nxt = frame_height_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH: begin
          line_width_nxt = cfg_wdata;
          col_nxt        = '0;
          row_nxt        = '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_nxt = cfg_wdata;
          col_nxt          = '0;
          row_nxt          = '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      line_width_r   <= line_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
    end
  end

  // ---------------------------------------------------------------- handshake
  assign rdy3     = !v3_r || rt_in_ready;
  assign rdy2     = !v2_r || rdy3;
  // border items do not need room downstream
  assign s1_go    = v1_r && (!prod1_r || rdy2);
  assign in_ready = !v1_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------- line store
  // word holds {row above the previous row, previous row} for one column
  assign line_d  = fwd_r ? fwd_d_r : rd_r;
  assign top_eff = line_d[2*PIX_W-1:PIX_W];
  assign mid_eff = line_d[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (s1_go) begin
      mem[c1_r] <= {mid_eff, pix1_r};
    end
    if (in_fire) begin
      rd_r <= mem[col_r];
    end
  end

  // write-back of the item leaving and read of the item entering can hit one entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_fire) begin
      fwd_r <= s1_go && (c1_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_d_r <= {mid_eff, pix1_r};
      pix1_r  <= in_pixel;
      c1_r    <= col_r;
      prod1_r <= produce;
      last1_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_fire) begin
      v1_r <= 1'b1;
    end else if (s1_go) begin
      v1_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- window
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_n[k*3+0] = win_r[k*3+1];
      win_n[k*3+1] = win_r[k*3+2];
    end
    win_n[2] = top_eff;
    win_n[5] = mid_eff;
    win_n[8] = pix1_r;
    sx_pos = (SUM_W-1)'(win_n[2]) + {(SUM_W-2)'(win_n[5]), 1'b0}
             + (SUM_W-1)'(win_n[8]);
    sx_neg = (SUM_W-1)'(win_n[0]) + {(SUM_W-2)'(win_n[3]), 1'b0}
             + (SUM_W-1)'(win_n[6]);
    sy_pos = (SUM_W-1)'(win_n[6]) + {(SUM_W-2)'(win_n[7]), 1'b0}
             + (SUM_W-1)'(win_n[8]);
    sy_neg = (SUM_W-1)'(win_n[0]) + {(SUM_W-2)'(win_n[1]), 1'b0}
             + (SUM_W-1)'(win_n[2]);
    sx_n = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
    sy_n = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (s1_go) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= win_n[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= s1_go && prod1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sx2_r   <= sx_n;
      sy2_r   <= sy_n;
      last2_r <= last1_r;
    end
  end

  // ---------------------------------------------------------------- squares
  always_comb begin
    px   = sx2_r * sx2_r;
    py   = sy2_r * sy2_r;
    sq_n = SQ_W'($unsigned(px)) + SQ_W'($unsigned(py));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sq3_r   <= sq_n[RAD_W-1:0];
      sat3_r  <= |sq_n[SQ_W-1:RAD_W];
      last3_r <= last2_r;
    end
  end

  // ---------------------------------------------------------------- root
  always_comb begin
    rt_in      = '0;
    rt_in.rad  = sq3_r;
    rt_in.sat  = sat3_r;
    rt_in.last = last3_r;
  end

  sgm_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (rt_in_ready),
    .in_data   (rt_in),
    .out_valid (rt_out_valid),
    .out_ready (out_ready),
    .out_data  (rt_out)
  );

  assign out_valid         = rt_out_valid;
  assign out_magnitude     = rt_out.sat ? MAG_MAX : rt_out.root;
  assign out_last_of_frame = rt_out.last;

  // ---------------------------------------------------------------- checks
  `SGM_ASSERT_SAME(a_stall_needs_item, !in_ready, v1_r, "input stalled with line stage empty")
  `SGM_ASSERT_NEXT(a_interior_moves_on, s1_go && prod1_r, v2_r, "interior item lost after window")
  `SGM_ASSERT_NEXT(a_line_stage_holds, v1_r && !s1_go, $stable(pix1_r) && $stable(c1_r),
                   "line stage item changed while stalled")

endmodule

>>> tb/tb_sobel_gradient_magnitude_unit.sv
// self-checking testbench for sobel_gradient_magnitude_unit: streams pixel frames, predicts
// each interior magnitude in a scoreboard class and checks every result in order
// depends on sgm_pkg and the unit's top level

typedef struct packed {
  logic [sgm_pkg::ROOT_W-1:0] mag;
  logic                       last;
} magnitude_t;

class gradient_scoreboard;
  localparam int LINE_CAP = 2048;

  logic [sgm_pkg::PIX_W-1:0] row_above  [LINE_CAP];
  logic [sgm_pkg::PIX_W-1:0] row_two_up [LINE_CAP];
  logic [sgm_pkg::PIX_W-1:0] win [9];
  int unsigned               col_pos;
  int unsigned               row_pos;
  logic [sgm_pkg::CFG_W-1:0] width_reg;
  logic [sgm_pkg::CFG_W-1:0] height_reg;
  magnitude_t                pending_magnitudes [$];
  int unsigned               errors;
  int unsigned               pixels_seen;
  int unsigned               magnitudes_checked;

  function new();
    width_reg  = sgm_pkg::LINE_WIDTH_RST;
    height_reg = sgm_pkg::FRAME_HEIGHT_RST;
    foreach (row_above[i]) begin
      row_above[i]  = '0;
      row_two_up[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_pos            = 0;
    row_pos            = 0;
    errors             = 0;
    pixels_seen        = 0;
    magnitudes_checked = 0;
  endfunction

  // any register write restarts the frame, window and line store stay
  function void write_register(sgm_pkg::sgm_reg_t idx, logic [sgm_pkg::CFG_W-1:0] v);
    case (idx)
      sgm_pkg::REG_LINE_WIDTH:   width_reg  = v;
      sgm_pkg::REG_FRAME_HEIGHT: height_reg = v;
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  function logic [sgm_pkg::ROOT_W-1:0] floor_root(int unsigned sq);
    logic [sgm_pkg::ROOT_W-1:0] r;
    int unsigned                t;
    if (sq >= 65536) return sgm_pkg::MAG_MAX;
    r = '0;
    for (int b = sgm_pkg::ROOT_W - 1; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= sq) r = t[sgm_pkg::ROOT_W-1:0];
    end
    return r;
  endfunction

  function void note_pixel(logic [sgm_pkg::PIX_W-1:0] p);
    int unsigned               w;
    int unsigned               h;
    int unsigned               c;
    logic [sgm_pkg::PIX_W-1:0] up2;
    logic [sgm_pkg::PIX_W-1:0] up1;
    int                        a [9];
    int                        sx;
    int                        sy;
    magnitude_t                e;
    w = width_reg;
    h = height_reg;
    if (w > LINE_CAP) w = LINE_CAP;
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    pixels_seen++;
    c = col_pos % LINE_CAP;
    up2 = row_two_up[c];
    up1 = row_above[c];
    row_two_up[c] = up1;
    row_above[c]  = p;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = p;
    if (row_pos >= 2 && c >= 2) begin
      foreach (win[i]) a[i] = win[i];
      sx = -a[0] + a[2] - 2 * a[3] + 2 * a[5] - a[6] + a[8];
      sy = -a[0] - 2 * a[1] - a[2] + a[6] + 2 * a[7] + a[8];
      e.mag  = floor_root(sx * sx + sy * sy);
      e.last = (row_pos + 1 == h) && (c + 1 == w);
      pending_magnitudes.push_back(e);
    end
    c++;
    if (c >= w) begin
      c = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    col_pos = c;
    row_pos = row_pos & 12'hFFF;
  endfunction

  function void check_magnitude(logic [sgm_pkg::ROOT_W-1:0] mag, logic last);
    magnitude_t e;
    if (pending_magnitudes.size() == 0) begin
      $error("magnitude %0d arrived with no interior pixel waiting", mag);
      errors++;
      return;
    end
    e = pending_magnitudes.pop_front();
    magnitudes_checked++;
    if (mag !== e.mag) begin
      $error("magnitude: expected %0d, got %0d", e.mag, mag);
      errors++;
    end
    if (last !== e.last) begin
      $error("last_of_frame: expected %0b, got %0b", e.last, last);
      errors++;
    end
  endfunction

  function void report_leftover();
    if (pending_magnitudes.size() != 0) begin
      $error("%0d expected magnitudes never arrived", pending_magnitudes.size());
      errors++;
    end
  endfunction
endclass

module tb_sobel_gradient_magnitude_unit;
  import sgm_pkg::*;

  localparam int MAX_W          = 2048;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int CALM_TAIL      = 200;

  typedef enum int {PAT_UNIFORM, PAT_EXTREME, PAT_LOW, PAT_MIXED} pattern_t;

  // column of 63 (just under the square threshold), column of 64 (exactly on it),
  // bright top rows over a dark bottom row (negative vertical sum)
  localparam logic [PIX_W-1:0] DIRECTED_PIX [27] = '{
    8'd0,   8'd0,   8'd63,  8'd0,   8'd0,   8'd63,  8'd0,   8'd0,   8'd63,
    8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd64,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0
  };
  // sizes too small for any interior pixel, zero among them
  localparam logic [CFG_W-1:0] ODD_W [7] = '{12'd0, 12'd1, 12'd2, 12'd5, 12'd4, 12'd6, 12'd0};
  localparam logic [CFG_W-1:0] ODD_H [7] = '{12'd5, 12'd4, 12'd6, 12'd0, 12'd1, 12'd2, 12'd0};

  logic                 clk               = 1'b0;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel          = '0;
  logic                 out_valid;
  logic                 out_ready         = 1'b0;
  logic [ROOT_W-1:0]    out_magnitude;
  logic                 out_last_of_frame;
  logic                 cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index         = REG_LINE_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata         = '0;

  gradient_scoreboard sb;
  bit                 gaps_on    = 1'b0;
  int                 stall_left = 0;
  int unsigned        cfg_writes = 0;
  int unsigned        cur_w      = 640;
  int unsigned        cur_h      = 480;

  sobel_gradient_magnitude_unit #(.MAX_WIDTH(MAX_W)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_magnitude     (out_magnitude),
    .out_last_of_frame (out_last_of_frame),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // results are checked before the same edge's item is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_register(sgm_reg_t'(cfg_index), cfg_wdata);
      if (out_valid && out_ready) sb.check_magnitude(out_magnitude, out_last_of_frame);
      if (in_valid && in_ready) sb.note_pixel(in_pixel);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL sobel_gradient_magnitude_unit");
    $finish;
  end

  function automatic logic [PIX_W-1:0] next_pixel(pattern_t mode);
    pattern_t pick;
    pick = (mode == PAT_MIXED) ? pattern_t'($urandom_range(0, 2)) : mode;
    case (pick)
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PAT_LOW:     return 8'($urandom_range(0, 7));
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_magnitudes.size() != 0) @(negedge clk);
  endtask

  // drain, then give border items still in the pipe time to leave
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input sgm_reg_t idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    if (idx == REG_LINE_WIDTH) cur_w = v;
    else cur_h = v;
  endtask

  task automatic run_pixels(input int unsigned n, input pattern_t mode);
    for (int unsigned i = 0; i < n; i++) begin
      send_pixel(next_pixel(mode));
      if (gaps_on && $urandom_range(0, 299) == 0) hold_until_drained();
    end
  endtask

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned frames;
    int unsigned tail;
    int unsigned pick;
    pattern_t    mode;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gaps_on = 1'b1;

    // reset sizes: the start of the first row, no interior pixel yet
    run_pixels(40, PAT_UNIFORM);
    settle();

    write_cfg(REG_LINE_WIDTH, 12'd3);
    write_cfg(REG_FRAME_HEIGHT, 12'd3);
    foreach (DIRECTED_PIX[i]) begin
      send_pixel(DIRECTED_PIX[i]);
      if (i == 8) hold_until_drained();
    end
    settle();

    // widest setting saturates to the store depth: the start of its first row
    write_cfg(REG_LINE_WIDTH, 12'hFFF);
    write_cfg(REG_FRAME_HEIGHT, 12'd3);
    run_pixels(40, PAT_MIXED);
    settle();

    // tallest frame, only its first rows
    write_cfg(REG_LINE_WIDTH, 12'd3);
    write_cfg(REG_FRAME_HEIGHT, 12'hFFF);
    run_pixels(60, PAT_MIXED);
    settle();

    foreach (ODD_W[i]) begin
      write_cfg(REG_LINE_WIDTH, ODD_W[i]);
      write_cfg(REG_FRAME_HEIGHT, ODD_H[i]);
      run_pixels(24, PAT_UNIFORM);
      settle();
    end

    // random sizes, whole frames with an occasional cut-off frame at the end
    // the first round sets both sizes, the odd sizes above left zeros behind
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      gaps_on = (random_sent + CALM_TAIL < RANDOM_ITEMS);
      pick = (random_sent == 0) ? 0 : $urandom_range(0, 3);
      if (pick != 2)
        write_cfg(REG_LINE_WIDTH,
                  12'($urandom_range(0, 9) == 0 ? $urandom_range(11, 40) : $urandom_range(3, 10)));
      if (pick != 1) write_cfg(REG_FRAME_HEIGHT, 12'($urandom_range(3, 7)));
      frames = $urandom_range(1, 3);
      tail   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cur_w * cur_h - 1) : 0;
      mode   = pattern_t'($urandom_range(0, 3));
      run_pixels(frames * cur_w * cur_h + tail, mode);
      random_sent += frames * cur_w * cur_h + tail;
      settle();
    end

    sb.report_leftover();
    $display("checked %0d magnitudes from %0d pixels across %0d register writes",
             sb.magnitudes_checked, sb.pixels_seen, cfg_writes);
    $display("sizes from zero and sub-window up to a saturated line, stalls on both sides");
    if (sb.errors == 0) begin
      $display("PASS sobel_gradient_magnitude_unit");
    end else begin
      $display("FAIL sobel_gradient_magnitude_unit");
    end
    $finish;
  end
endmodule

>>> sobel_gradient_magnitude_unit.f
+incdir+src
src/sgm_pkg.sv
src/sgm_isqrt.sv
src/sobel_gradient_magnitude_unit.sv
tb/tb_sobel_gradient_magnitude_unit.sv
